### design/sorted_table_lower_bound_unit_defines.svh
// Assertion macros shared by the lower-bound search block.
`ifndef SORTED_TABLE_LOWER_BOUND_UNIT_DEFINES_SVH
`define SORTED_TABLE_LOWER_BOUND_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STLB_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define STLB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/stlb_pkg.sv
`timescale 1ns / 1ps

package stlb_pkg;

  localparam int KEY_W = 32;
  localparam int IDX_W = 10;
  localparam int CNT_W = 11;
  localparam int POS_W = 11;

  localparam int TABLE_DEPTH_DEF = 1024;

  typedef enum logic [0:0] {
    MODE_LOAD  = 1'b0,
    MODE_QUERY = 1'b1
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_TAIL,
    ST_SEARCH,
    ST_EMIT
  } state_e;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [POS_W-1:0]        pos_t;

endpackage

### design/stlb_ifs.sv
`timescale 1ns / 1ps

// Request channel: one load or one query per accepted request.
interface stlb_req_if;
  logic                valid;
  logic                ready;
  stlb_pkg::mode_e     mode;
  stlb_pkg::idx_t      entry_index;
  stlb_pkg::key_t      key_value;

  modport source (output valid, output mode, output entry_index, output key_value,
                  input ready);
  modport sink   (input valid, input mode, input entry_index, input key_value,
                  output ready);
endinterface

// Response channel: one position per query.
interface stlb_rsp_if;
  logic                valid;
  logic                ready;
  stlb_pkg::pos_t      lower_bound_position;

  modport source (output valid, output lower_bound_position, input ready);
  modport sink   (input valid, input lower_bound_position, output ready);
endinterface

### design/stlb_ram.sv
`timescale 1ns / 1ps

module stlb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/sorted_table_lower_bound_unit.sv
// Channel   Dir  Payload                                  Accepted when
// req_i     in   mode, entry_index[9:0], key_value[31:0]  valid && ready
// rsp_o     out  lower_bound_position[10:0]               valid && ready
// cfg       in   cfg_wdata_i[10:0] (key_count)            cfg_we_i
//
// A load writes the key table RAM when it is accepted.
// A query holds the unit through HEAD, TAIL, SEARCH (while the span is open) and EMIT;
// its result is registered in EMIT, when the unit is ready again. An empty table goes
// straight to EMIT. The single RAM read port feeds one key compare each cycle. A finished
// result sits in an output register; a stalled response only holds the next query at its
// final step. Reset clears the control state and key_count.
`timescale 1ns / 1ps
`include "sorted_table_lower_bound_unit_defines.svh"

module sorted_table_lower_bound_unit #(
  parameter int TABLE_DEPTH = stlb_pkg::TABLE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  stlb_pkg::cnt_t       cfg_wdata_i,
  stlb_req_if.sink             req_i,
  stlb_rsp_if.source           rsp_o
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = ((AW > stlb_pkg::IDX_W) ? AW : stlb_pkg::IDX_W) + 1;
  localparam int NW = (CW > stlb_pkg::CNT_W) ? CW : stlb_pkg::CNT_W;
  localparam int PW = (CW > stlb_pkg::POS_W) ? CW : stlb_pkg::POS_W;

  stlb_pkg::state_e state_q, state_d;
  stlb_pkg::cnt_t   key_count_q;
  stlb_pkg::key_t   key_q, key_d;
  logic [CW-1:0]    n_q, n_d;
  logic [AW-1:0]    lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [CW-1:0]    pos_q, pos_d;
  logic             out_vld_q, out_vld_d;
  stlb_pkg::pos_t   out_pos_q, out_pos_d;

  logic             req_fire;
  logic             out_load;
  logic [NW-1:0]    cnt_ext;
  logic [CW-1:0]    n_sat;
  logic [IW-1:0]    idx_ext;
  logic             ram_we;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  stlb_pkg::key_t   ram_rdata;
  logic             key_lt;
  logic [AW-1:0]    n_m1;
  logic [AW-1:0]    sel_lo, sel_hi, mid_w;
  logic [AW:0]      span_sum;

  // Key table
  assign idx_ext = IW'(req_i.entry_index);
  assign ram_we  = req_fire && (req_i.mode == stlb_pkg::MODE_LOAD) &&
                   (idx_ext < IW'(TABLE_DEPTH));

  stlb_ram #(
    .WIDTH (stlb_pkg::KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_ext[AW-1:0]),
    .wdata_i (req_i.key_value),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= '0;
    end else if (cfg_we_i) begin
      key_count_q <= cfg_wdata_i;
    end
  end

  // Saturate the count to the table depth
  assign cnt_ext = NW'(key_count_q);
  assign n_sat   = (cnt_ext > NW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(cnt_ext);

  assign req_i.ready = (state_q == stlb_pkg::ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  // Shared compare and midpoint unit
  assign key_lt   = ram_rdata < key_q;
  assign n_m1     = AW'(n_q - CW'(1));
  assign span_sum = {1'b0, sel_lo} + {1'b0, sel_hi};
  assign mid_w    = span_sum[AW:1];

  always_comb begin
    state_d   = state_q;
    key_d     = key_q;
    n_d       = n_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    pos_d     = pos_q;
    ram_re    = 1'b0;
    ram_raddr = '0;
    out_load  = 1'b0;
    sel_lo    = lo_q;
    sel_hi    = hi_q;

    case (state_q)
      stlb_pkg::ST_IDLE: begin
        if (req_fire && (req_i.mode == stlb_pkg::MODE_QUERY)) begin
          key_d = req_i.key_value;
          n_d   = n_sat;
          if (n_sat == '0) begin
            pos_d   = '0;
            state_d = stlb_pkg::ST_EMIT;
          end else begin
            ram_re  = 1'b1;
            state_d = stlb_pkg::ST_HEAD;
          end
        end
      end
      stlb_pkg::ST_HEAD: begin
        if (!key_lt) begin
          pos_d   = '0;
          state_d = stlb_pkg::ST_EMIT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = n_m1;
          state_d   = stlb_pkg::ST_TAIL;
        end
      end
      stlb_pkg::ST_TAIL: begin
        sel_lo = '0;
        sel_hi = n_m1;
        if (key_lt) begin
          pos_d   = n_q;
          state_d = stlb_pkg::ST_EMIT;
        end else if (sel_lo < sel_hi) begin
          lo_d      = sel_lo;
          hi_d      = sel_hi;
          mid_d     = mid_w;
          ram_re    = 1'b1;
          ram_raddr = mid_w;
          state_d   = stlb_pkg::ST_SEARCH;
        end else begin
          pos_d   = '0;
          state_d = stlb_pkg::ST_EMIT;
        end
      end
      stlb_pkg::ST_SEARCH: begin
        // Narrow the span on the key read at the midpoint
        sel_lo = key_lt ? AW'(mid_q + AW'(1)) : lo_q;
        sel_hi = key_lt ? hi_q : mid_q;
        lo_d   = sel_lo;
        hi_d   = sel_hi;
        if (sel_lo < sel_hi) begin
          mid_d     = mid_w;
          ram_re    = 1'b1;
          ram_raddr = mid_w;
        end else begin
          pos_d   = CW'(sel_lo);
          state_d = stlb_pkg::ST_EMIT;
        end
      end
      stlb_pkg::ST_EMIT: begin
        // Hold until the output register is free
        if (!out_vld_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = stlb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = stlb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    out_pos_d = out_pos_q;
    if (out_load) begin
      out_vld_d = 1'b1;
      out_pos_d = stlb_pkg::POS_W'(PW'(pos_q));
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= stlb_pkg::ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    n_q       <= n_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    mid_q     <= mid_d;
    pos_q     <= pos_d;
    out_pos_q <= out_pos_d;
  end

  assign rsp_o.valid                = out_vld_q;
  assign rsp_o.lower_bound_position = out_pos_q;

  `STLB_ASSERT_IMPL(a_span_order, clk_i, rst_ni, state_q == stlb_pkg::ST_SEARCH, (lo_q <= mid_q) && (mid_q < hi_q) && (CW'(hi_q) < n_q), "search span out of order")
  `STLB_ASSERT_IMPL(a_pos_in_range, clk_i, rst_ni, state_q == stlb_pkg::ST_EMIT, pos_q <= n_q, "result beyond key count")
  `STLB_ASSERT_NEXT(a_query_start, clk_i, rst_ni, req_fire && (req_i.mode == stlb_pkg::MODE_QUERY), (state_q == stlb_pkg::ST_HEAD) || (state_q == stlb_pkg::ST_EMIT), "query did not start")
  `STLB_ASSERT_IMPL(a_write_idle, clk_i, rst_ni, ram_we, (state_q == stlb_pkg::ST_IDLE) && !ram_re, "table write during search")

endmodule

### verif/tb_sorted_table_lower_bound_unit.sv
`timescale 1ns / 1ps

// Tracks the key table and key count, predicts the position for each query
// request and checks the returned positions in order.
class lower_bound_scoreboard;
  stlb_pkg::key_t keys [stlb_pkg::TABLE_DEPTH_DEF];
  stlb_pkg::cnt_t key_count = '0;
  stlb_pkg::pos_t expected_positions [$];
  int   mismatches = 0;
  int   checked = 0;

  function void set_count(stlb_pkg::cnt_t value);
    key_count = value;
  endfunction

  function stlb_pkg::pos_t lower_bound(stlb_pkg::key_t probe);
    int unsigned n, lo, hi, mid;
    // saturate the count at the table depth
    n = (key_count > stlb_pkg::TABLE_DEPTH_DEF) ? stlb_pkg::TABLE_DEPTH_DEF : key_count;
    if (n == 0) return '0;
    if (!(keys[0] < probe)) return '0;
    if (keys[n - 1] < probe) return stlb_pkg::pos_t'(n);
    lo = 0;
    hi = n - 1;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (keys[mid] < probe) lo = mid + 1;
      else hi = mid;
    end
    return stlb_pkg::pos_t'(lo);
  endfunction

  function void note_request(stlb_pkg::mode_e mode, stlb_pkg::idx_t index,
                             stlb_pkg::key_t key_value);
    if (mode == stlb_pkg::MODE_LOAD) keys[index] = key_value;
    else expected_positions.push_back(lower_bound(key_value));
  endfunction

  task report_mismatch(string what);
    mismatches++;
    $display("%0t: mismatch: %s", $time, what);
  endtask

  task check_result(stlb_pkg::pos_t got);
    stlb_pkg::pos_t want;
    if (expected_positions.size() == 0) begin
      report_mismatch($sformatf("position %0d returned with no query pending", got));
      return;
    end
    want = expected_positions.pop_front();
    checked++;
    if (got !== want)
      report_mismatch($sformatf("lower_bound_position %0d, expected %0d", got, want));
  endtask
endclass

module tb_sorted_table_lower_bound_unit;
  localparam int   TABLE_DEPTH   = stlb_pkg::TABLE_DEPTH_DEF;
  localparam int   RANDOM_ITEMS  = 1150;
  localparam int   QUIET_TAIL    = 120;
  localparam int   SETTLE_CYCLES = 20;
  localparam int   LIMIT_NS      = 10_000_000;
  localparam stlb_pkg::key_t KEY_MIN = stlb_pkg::key_t'(32'h8000_0000);
  localparam stlb_pkg::key_t KEY_MAX = stlb_pkg::key_t'(32'h7fff_ffff);

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  stlb_pkg::cnt_t cfg_wdata_i;

  stlb_req_if req_if ();
  stlb_rsp_if rsp_if ();

  sorted_table_lower_bound_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  lower_bound_scoreboard sb;

  bit req_idle_on;
  bit rsp_stall_on;
  bit counting;
  int rsp_stall_left;
  int random_items;
  int loads_sent;
  int queries_sent;
  int count_writes;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  task automatic send_request(stlb_pkg::mode_e mode, stlb_pkg::idx_t index,
                              stlb_pkg::key_t key_value);
    int gap;
    gap = (req_idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.mode        <= mode;
    req_if.entry_index <= index;
    req_if.key_value   <= key_value;
    // hold the request until the block takes it
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    sb.note_request(mode, index, key_value);
    if (mode == stlb_pkg::MODE_LOAD) loads_sent++;
    else queries_sent++;
    if (counting) random_items++;
  endtask

  task automatic load_entry(stlb_pkg::idx_t index, stlb_pkg::key_t key_value);
    send_request(stlb_pkg::MODE_LOAD, index, key_value);
  endtask

  task automatic query_key(stlb_pkg::key_t key_value);
    send_request(stlb_pkg::MODE_QUERY, stlb_pkg::idx_t'($urandom), key_value);
  endtask

  // Drop valid, wait for every pending position, then let a search's worth of
  // cycles pass so that the block is surely idle.
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (sb.expected_positions.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_key_count(stlb_pkg::cnt_t value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_count(value);
    count_writes++;
  endtask

  function automatic stlb_pkg::key_t random_key(stlb_pkg::key_t center, int spread);
    case ($urandom_range(0, 15))
      0:       return KEY_MIN;
      1:       return KEY_MAX;
      default: return (spread == 0) ? stlb_pkg::key_t'($urandom)
                                    : center + $urandom_range(0, 2 * spread) - spread;
    endcase
  endfunction

  // Pick a query key around the keys in use, so that most searches end inside the table.
  function automatic stlb_pkg::key_t query_probe();
    int n;
    int pick;
    n = (sb.key_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(sb.key_count);
    if (n == 0) return ($urandom_range(0, 3) == 0) ? KEY_MIN : stlb_pkg::key_t'($urandom);
    pick = $urandom_range(0, n - 1);
    case ($urandom_range(0, 6))
      0, 1:    return sb.keys[pick];
      2:       return sb.keys[pick] + 1;
      3:       return sb.keys[pick] - 1;
      4:       return ($urandom_range(0, 1) == 0) ? sb.keys[0] - 1 : sb.keys[n - 1] + 1;
      5:       return ($urandom_range(0, 1) == 0) ? KEY_MIN : KEY_MAX;
      default: return stlb_pkg::key_t'($urandom);
    endcase
  endfunction

  // Load entries 0 .. n-1 with fresh keys, sorted unless asked otherwise, and now
  // and then a stray request beyond the prefix.
  task automatic load_prefix(int n, bit ordered, int spread);
    stlb_pkg::key_t fresh [$];
    stlb_pkg::key_t center;
    stlb_pkg::key_t held;
    int   j;
    center = stlb_pkg::key_t'($urandom);
    for (int i = 0; i < n; i++) fresh.push_back(random_key(center, spread));
    if (ordered) begin
      for (int i = 1; i < n; i++) begin
        held = fresh[i];
        j    = i - 1;
        while (j >= 0 && fresh[j] > held) begin
          fresh[j + 1] = fresh[j];
          j--;
        end
        fresh[j + 1] = held;
      end
    end
    for (int i = 0; i < n; i++) begin
      load_entry(stlb_pkg::idx_t'(i), fresh[i]);
      if (n < TABLE_DEPTH && $urandom_range(0, 9) == 0)
        load_entry(stlb_pkg::idx_t'($urandom_range(n, TABLE_DEPTH - 1)),
                   stlb_pkg::key_t'($urandom));
    end
  endtask

  task automatic run_queries(int count);
    for (int i = 0; i < count; i++) begin
      // a stray load may land inside the keys in use and break the order
      if ($urandom_range(0, 9) == 0)
        load_entry(stlb_pkg::idx_t'($urandom), stlb_pkg::key_t'($urandom));
      else query_key(query_probe());
    end
  endtask

  initial begin
    rsp_if.ready <= 1'b0;
    rsp_stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        sb.check_result(rsp_if.lower_bound_position);
      if (rsp_stall_left > 0) begin
        rsp_stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (rsp_stall_on && $urandom_range(0, 5) == 0) begin
        rsp_stall_left = $urandom_range(0, 7);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    int n;
    int phase;
    bit tail;
    bit full_loaded;

    sb = new;
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_wdata_i        <= '0;
    req_if.valid       <= 1'b0;
    req_if.mode        <= stlb_pkg::MODE_LOAD;
    req_if.entry_index <= '0;
    req_if.key_value   <= '0;
    req_idle_on  = 1'b1;
    rsp_stall_on = 1'b1;
    counting     = 1'b0;
    full_loaded  = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty table straight after reset
    query_key(KEY_MIN);
    query_key(KEY_MAX);
    query_key('0);

    // four keys with a duplicate pair, plus the top entry
    load_entry(stlb_pkg::idx_t'(0), KEY_MIN);
    load_entry(stlb_pkg::idx_t'(1), stlb_pkg::key_t'(-5));
    load_entry(stlb_pkg::idx_t'(2), stlb_pkg::key_t'(-5));
    load_entry(stlb_pkg::idx_t'(3), stlb_pkg::key_t'(100));
    load_entry(stlb_pkg::idx_t'(TABLE_DEPTH - 1), '0);
    set_key_count(stlb_pkg::cnt_t'(4));
    query_key(KEY_MIN);
    query_key(stlb_pkg::key_t'(-5));
    query_key(stlb_pkg::key_t'(-4));
    query_key(stlb_pkg::key_t'(100));
    query_key(stlb_pkg::key_t'(101));
    query_key(KEY_MAX);

    set_key_count(stlb_pkg::cnt_t'(1));
    query_key(KEY_MIN);
    query_key(KEY_MAX);

    // out-of-order table
    load_entry(stlb_pkg::idx_t'(1), stlb_pkg::key_t'(200));
    set_key_count(stlb_pkg::cnt_t'(4));
    query_key(stlb_pkg::key_t'(50));

    counting = 1'b1;
    phase    = 0;
    while (random_items < RANDOM_ITEMS) begin
      tail         = (random_items >= RANDOM_ITEMS - QUIET_TAIL);
      req_idle_on  = !tail && $urandom_range(0, 3) != 0;
      rsp_stall_on = !tail && $urandom_range(0, 3) != 0;
      if (phase == 0) begin
        // fill the whole table once, then search it at full, saturated and smaller counts
        load_prefix(TABLE_DEPTH, 1'b1, 0);
        full_loaded = 1'b1;
        set_key_count(stlb_pkg::cnt_t'(TABLE_DEPTH));
        run_queries(40);
        set_key_count('1);
        run_queries(15);
        set_key_count(stlb_pkg::cnt_t'($urandom_range(65, TABLE_DEPTH - 1)));
        run_queries(15);
      end else begin
        case ($urandom_range(0, 9))
          0:       n = 0;
          1:       n = 1;
          2:       n = full_loaded ? TABLE_DEPTH : 2;
          default: n = $urandom_range(2, 48);
        endcase
        if (n < TABLE_DEPTH) begin
          case ($urandom_range(0, 2))
            0:       load_prefix(n, $urandom_range(0, 7) != 0, 0);
            1:       load_prefix(n, $urandom_range(0, 7) != 0, 3);
            default: load_prefix(n, $urandom_range(0, 7) != 0, 1000);
          endcase
        end
        set_key_count(stlb_pkg::cnt_t'(n));
        run_queries($urandom_range(8, 30));
      end
      phase++;
    end

    wait_idle();
    $display("Checked %0d positions from %0d queries and %0d loads over %0d key-count writes.",
             sb.checked, queries_sent, loads_sent, count_writes);
    $display("Tables searched: empty, single key, duplicates, unsorted, full depth, saturated.");
    if (sb.mismatches == 0) begin
      $display("tb_sorted_table_lower_bound_unit OK");
    end else begin
      $display("tb_sorted_table_lower_bound_unit NOT OK");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("tb_sorted_table_lower_bound_unit NOT OK");
    $finish;
  end
endmodule
